// File: sv/sia_pkg.sv
// Package for the signed integer ALU: command codes and the per-stage record
// that travels with each item. No dependencies.
package sia_pkg;

    localparam logic [2:0] CMD_ADD = 3'd0;
    localparam logic [2:0] CMD_SUB = 3'd1;
    localparam logic [2:0] CMD_DIV = 3'd2;
    localparam logic [2:0] CMD_MUL = 3'd3;
    localparam logic [2:0] CMD_REM = 3'd4;

    typedef struct packed {
        logic       is_div;
        logic       is_rem;
        logic       neg_q;
        logic       neg_r;
        logic       div_zero;
    } t_div_ctl;

endpackage

// File: sv/sia_mul_pipe.sv
// Pipelined low-half multiplier built from three half-width partial products.
// Depends on nothing; the depth is matched to the divider by the top level.
module sia_mul_pipe #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [DATA_WIDTH-1:0] i_a,
    input  logic [DATA_WIDTH-1:0] i_b,
    output logic [DATA_WIDTH-1:0] o_p
);
    localparam int H = DATA_WIDTH / 2;
    localparam int L = DATA_WIDTH - H;

    logic [DATA_WIDTH-1:0] r_lo;
    logic [DATA_WIDTH-1:0] r_cross;
    logic [DATA_WIDTH-1:0] r_p;

    // Only the low word is kept, so the high-by-high product is never needed.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lo    <= DATA_WIDTH'({{L{1'b0}}, i_a[L-1:0]} * {{L{1'b0}}, i_b[L-1:0]});
            r_cross <= (DATA_WIDTH'(i_a[DATA_WIDTH-1:L] * i_b[L-1:0])
                      + DATA_WIDTH'(i_b[DATA_WIDTH-1:L] * i_a[L-1:0])) << L;
            r_p     <= r_lo + r_cross;
        end
    end

    assign o_p = r_p;
endmodule

// File: sv/sia_div_pipe.sv
// Pipelined restoring divider on magnitudes, one quotient bit per stage.
// Depends on nothing; the stall enable freezes every stage together.
module sia_div_pipe #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [DATA_WIDTH-1:0] i_n,
    input  logic [DATA_WIDTH-1:0] i_d,
    output logic [DATA_WIDTH-1:0] o_q,
    output logic [DATA_WIDTH-1:0] o_r
);
    logic [DATA_WIDTH-1:0] r_rem [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0] r_num [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0] r_den [DATA_WIDTH+1];
    logic [DATA_WIDTH:0]   w_shift [DATA_WIDTH];
    logic [DATA_WIDTH:0]   w_diff  [DATA_WIDTH];

    always_comb begin
        for (int s = 0; s < DATA_WIDTH; s++) begin
            w_shift[s] = {r_rem[s], r_num[s][DATA_WIDTH-1]};
            w_diff[s]  = w_shift[s] - {1'b0, r_den[s]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= '0;
            r_num[0] <= i_n;
            r_den[0] <= i_d;
            for (int s = 0; s < DATA_WIDTH; s++) begin
                r_den[s+1] <= r_den[s];
                if (!w_diff[s][DATA_WIDTH]) begin
                    r_rem[s+1] <= w_diff[s][DATA_WIDTH-1:0];
                    r_num[s+1] <= {r_num[s][DATA_WIDTH-2:0], 1'b1};
                end else begin
                    r_rem[s+1] <= w_shift[s][DATA_WIDTH-1:0];
                    r_num[s+1] <= {r_num[s][DATA_WIDTH-2:0], 1'b0};
                end
            end
        end
    end

    // After the last stage the dividend register holds the quotient bits.
    assign o_q = r_num[DATA_WIDTH];
    assign o_r = r_rem[DATA_WIDTH];
endmodule

// File: sv/signed_int_alu_div_mod_core.sv
// Each item passes through the stage registers and then the output register.
// Throughput one item per cycle while the output is not stalled; the divider has one stage per quotient bit.
// A stalled output freezes the whole pipeline together, and the input is
// not ready while the output holds an item that is not taken.
// Synchronous active-low reset clears the valid bits only.
// Top level of the signed ALU; uses sia_pkg, sia_mul_pipe and sia_div_pipe.
module signed_int_alu_div_mod_core #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [2:0]            i_command,
    input  logic [DATA_WIDTH-1:0] i_operand_a,
    input  logic [DATA_WIDTH-1:0] i_operand_b,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [DATA_WIDTH-1:0] o_result,
    output logic                  o_status
);
    import sia_pkg::*;

    localparam int DEPTH = DATA_WIDTH + 1;   // stages between input and output register

    logic                  r_vld   [DEPTH];
    logic [DATA_WIDTH-1:0] r_sum   [DEPTH];
    t_div_ctl              r_ctl   [DEPTH];
    logic                  r_ismul [DEPTH];
    logic                  r_out_v;
    logic [DATA_WIDTH-1:0] r_out_d;
    logic                  r_out_s;

    logic                  w_adv;
    logic [DATA_WIDTH-1:0] w_ma, w_mb, w_q, w_r, w_p, n_res;
    logic                  w_na, w_nb;
    t_div_ctl              w_ctl;
    logic [DATA_WIDTH-1:0] w_sum;

    // The pipeline moves whenever the output slot is free or being emptied.
    assign w_adv   = !r_out_v || i_ready;
    assign o_ready = w_adv;

    assign w_na = i_operand_a[DATA_WIDTH-1];
    assign w_nb = i_operand_b[DATA_WIDTH-1];
    assign w_ma = w_na ? -i_operand_a : i_operand_a;
    assign w_mb = w_nb ? -i_operand_b : i_operand_b;

    always_comb begin
        w_ctl          = '0;
        w_ctl.is_div   = (i_command == CMD_DIV);
        w_ctl.is_rem   = (i_command == CMD_REM);
        w_ctl.neg_q    = w_na ^ w_nb;
        w_ctl.neg_r    = w_na;
        w_ctl.div_zero = (i_operand_b == '0);
        case (i_command)
            CMD_ADD: w_sum = i_operand_a + i_operand_b;
            CMD_SUB: w_sum = i_operand_a - i_operand_b;
            default: w_sum = '0;
        endcase
    end

    sia_mul_pipe #(.DATA_WIDTH(DATA_WIDTH)) u_mul (
        .i_clk(i_clk), .i_en(w_adv), .i_a(i_operand_a), .i_b(i_operand_b), .o_p(w_p)
    );

    sia_div_pipe #(.DATA_WIDTH(DATA_WIDTH)) u_div (
        .i_clk(i_clk), .i_en(w_adv), .i_n(w_ma), .i_d(w_mb), .o_q(w_q), .o_r(w_r)
    );

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sum[0]   <= w_sum;
            r_ctl[0]   <= w_ctl;
            r_ismul[0] <= (i_command == CMD_MUL);
            for (int s = 1; s < DEPTH; s++) begin
                r_sum[s]   <= r_sum[s-1];
                r_ctl[s]   <= r_ctl[s-1];
                r_ismul[s] <= r_ismul[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < DEPTH; s++) r_vld[s] <= 1'b0;
        end else if (w_adv) begin
            r_vld[0] <= i_valid;
            for (int s = 1; s < DEPTH; s++) r_vld[s] <= r_vld[s-1];
        end
    end

    // The multiplier product is ready after two stages; it enters stage 2
    // here and rides along with the sum lane to the last stage.
    logic [DATA_WIDTH-1:0] r_mul [DEPTH-2];
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_mul[0] <= w_p;
            for (int s = 1; s < DEPTH - 2; s++) r_mul[s] <= r_mul[s-1];
        end
    end

    always_comb begin
        t_div_ctl c;
        c = r_ctl[DEPTH-1];
        n_res = r_sum[DEPTH-1];
        if (r_ismul[DEPTH-1]) begin
            n_res = r_mul[DEPTH-3];
        end else if ((c.is_div || c.is_rem) && c.div_zero) begin
            n_res = '0;
        end else if (c.is_div) begin
            n_res = c.neg_q ? -w_q : w_q;
        end else if (c.is_rem) begin
            n_res = c.neg_r ? -w_r : w_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_adv) begin
            r_out_v <= r_vld[DEPTH-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_d <= n_res;
            r_out_s <= (r_ctl[DEPTH-1].is_div || r_ctl[DEPTH-1].is_rem)
                       && r_ctl[DEPTH-1].div_zero;
        end
    end

    assign o_valid  = r_out_v;
    assign o_result = r_out_d;
    assign o_status = r_out_s;

`ifndef SYNTHESIS
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_result) && $stable(o_status))
        else $error("output changed during stall");
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("not ready with empty output");
    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> o_result == '0)
        else $error("error result not zero");
`endif
endmodule

// File: tb/alu_checker.sv
// Checker for the signed integer ALU: watches both transfer channels, predicts each
// result and compares it with what the block returns. Depends on sia_pkg.
`timescale 1ns / 100ps

module alu_checker #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic                  i_in_ready,
    input  logic [2:0]            i_command,
    input  logic [DATA_WIDTH-1:0] i_operand_a,
    input  logic [DATA_WIDTH-1:0] i_operand_b,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [DATA_WIDTH-1:0] i_result,
    input  logic                  i_status,
    output int                    o_fail_count,
    output int                    o_pending
);
    import sia_pkg::*;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] value;
        logic                  status;
    } t_alu_result;

    t_alu_result expected_results[$];

    assign o_pending = expected_results.size();

    function automatic t_alu_result compute_alu(input logic [2:0] cmd,
                                                input logic [DATA_WIDTH-1:0] a,
                                                input logic [DATA_WIDTH-1:0] b);
        t_alu_result r;
        logic [DATA_WIDTH-1:0] mag_a;
        logic [DATA_WIDTH-1:0] mag_b;
        logic [DATA_WIDTH-1:0] quot;
        logic [DATA_WIDTH-1:0] rem;
        r = '0;
        mag_a = a[DATA_WIDTH-1] ? -a : a;
        mag_b = b[DATA_WIDTH-1] ? -b : b;
        case (cmd)
            CMD_ADD: r.value = a + b;
            CMD_SUB: r.value = a - b;
            CMD_MUL: r.value = a * b;
            CMD_DIV, CMD_REM: begin
                if (b == '0) begin
                    r.status = 1'b1;
                end else begin
                    // Unsigned division on magnitudes avoids the wrapping corner.
                    quot = mag_a / mag_b;
                    rem  = mag_a % mag_b;
                    if (cmd == CMD_DIV)
                        r.value = (a[DATA_WIDTH-1] != b[DATA_WIDTH-1]) ? -quot : quot;
                    else
                        r.value = a[DATA_WIDTH-1] ? -rem : rem;
                end
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $realtime, msg);
        o_fail_count++;
    endtask

    initial o_fail_count = 0;

    always @(posedge i_clk) begin
        t_alu_result want;
        if (i_rst_n && i_valid && i_in_ready)
            expected_results.push_back(compute_alu(i_command, i_operand_a, i_operand_b));
        if (i_rst_n && i_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                want = expected_results.pop_front();
                if (i_result !== want.value)
                    report_mismatch($sformatf("result %h expected %h", i_result, want.value));
                if (i_status !== want.status)
                    report_mismatch($sformatf("status %b expected %b", i_status, want.status));
            end
        end
    end
endmodule

// File: tb/testbench.sv
// Top of the signed ALU testbench: clock, reset, stimulus, output stalls and the
// verdict. Depends on sia_pkg, signed_int_alu_div_mod_core and alu_checker.
`timescale 1ns / 100ps

module testbench;
    import sia_pkg::*;

    localparam int DW = 32;
    localparam logic [DW-1:0] MOST_NEG = {1'b1, {(DW-1){1'b0}}};
    localparam logic [DW-1:0] MOST_POS = {1'b0, {(DW-1){1'b1}}};

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_ready;
    logic [2:0]    command = CMD_ADD;
    logic [DW-1:0] operand_a = '0;
    logic [DW-1:0] operand_b = '0;
    logic          out_valid;
    logic          out_ready = 1'b0;
    logic [DW-1:0] result;
    logic          status;
    int            fail_count;
    int            pending;
    bit            calm = 1'b0;

    always #5 i_clk = ~i_clk;

    signed_int_alu_div_mod_core #(.DATA_WIDTH(DW)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(in_valid), .o_ready(in_ready),
        .i_command(command), .i_operand_a(operand_a), .i_operand_b(operand_b),
        .o_valid(out_valid), .i_ready(out_ready),
        .o_result(result), .o_status(status)
    );

    alu_checker #(.DATA_WIDTH(DW)) checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(in_valid), .i_in_ready(in_ready),
        .i_command(command), .i_operand_a(operand_a), .i_operand_b(operand_b),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_result(result), .i_status(status),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // The receiver stalls now and then, except during the calm stretch.
    always @(negedge i_clk)
        out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 8);

    function automatic logic [DW-1:0] random_operand();
        logic [DW-1:0] v;
        v = $urandom;
        case ($urandom_range(7))
            0: v = MOST_NEG;
            1: v = MOST_POS;
            2: v = {DW{1'b1}};
            3: v = $urandom_range(3);
            4: v = {{(DW-8){v[7]}}, v[7:0]};
            default: ;
        endcase
        return v;
    endfunction

    // Presents one item and holds it until the transfer happens. Valid stays
    // high into the next item unless the sender idles first.
    task automatic send_item(input logic [2:0] cmd, input logic [DW-1:0] a,
                             input logic [DW-1:0] b);
        while (!calm && $urandom_range(99) < 8) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        command   <= cmd;
        operand_a <= a;
        operand_b <= b;
        in_valid  <= 1'b1;
        @(posedge i_clk);
        while (!in_ready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        logic [2:0] cmd;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_item(CMD_ADD, MOST_POS, DW'(1));
        send_item(CMD_ADD, {DW{1'b1}}, {DW{1'b1}});
        send_item(CMD_SUB, MOST_NEG, DW'(1));
        send_item(CMD_SUB, '0, MOST_NEG);
        send_item(CMD_MUL, MOST_POS, MOST_POS);
        send_item(CMD_MUL, MOST_NEG, {DW{1'b1}});
        send_item(CMD_MUL, {DW{1'b1}}, {DW{1'b1}});
        send_item(CMD_DIV, DW'(7), DW'(-2));
        send_item(CMD_DIV, DW'(-7), DW'(2));
        send_item(CMD_DIV, DW'(5), '0);
        send_item(CMD_DIV, MOST_NEG, {DW{1'b1}});
        send_item(CMD_DIV, MOST_NEG, DW'(1));
        send_item(CMD_DIV, MOST_POS, MOST_NEG);
        send_item(CMD_REM, DW'(-7), DW'(2));
        send_item(CMD_REM, DW'(7), DW'(-2));
        send_item(CMD_REM, DW'(5), '0);
        send_item(CMD_REM, MOST_NEG, {DW{1'b1}});
        send_item(CMD_REM, MOST_NEG, MOST_POS);
        send_item(3'd5, MOST_NEG, DW'(3));
        send_item(3'd6, {DW{1'b1}}, {DW{1'b1}});
        send_item(3'd7, DW'(1), '0);
        in_valid <= 1'b0;

        // Let the pipeline drain completely before the random part.
        while (pending != 0)
            @(negedge i_clk);

        for (int n = 0; n < 500; n++) begin
            calm = (n >= 150 && n < 250);
            cmd = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5))
                                           : 3'($urandom_range(4));
            send_item(cmd, random_operand(),
                      ($urandom_range(15) == 0) ? '0 : random_operand());
        end
        in_valid <= 1'b0;
        calm = 1'b0;

        while (pending != 0)
            @(negedge i_clk);
        repeat (40) @(negedge i_clk);

        if (fail_count == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
